/* hdl/rct_pkg.sv */
`timescale 1ns / 1ps

package rct_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int COUNT_BITS_DEF    = 16;
    localparam int ADDRESS_BITS_DEF  = 32;

    localparam int OUT_STATUS_BITS = 2;
    localparam int OUT_COUNT_BITS  = 16;
    localparam int OUT_SLOT_BITS   = 4;
    localparam int OUT_FIELD_BITS  = OUT_STATUS_BITS + 2 * OUT_COUNT_BITS + 1 + OUT_SLOT_BITS;
    localparam int OUT_DATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_ASSIGN   = 1'b1;

    localparam logic [OUT_STATUS_BITS-1:0] STATUS_OK          = 2'd0;
    localparam logic [OUT_STATUS_BITS-1:0] STATUS_FULL        = 2'd1;
    localparam logic [OUT_STATUS_BITS-1:0] STATUS_OLD_MISSING = 2'd2;
    localparam logic [OUT_STATUS_BITS-1:0] STATUS_NEW_MISSING = 2'd3;

    typedef enum logic [1:0] {
        OP_REG,
        OP_DEC,
        OP_INC
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS_A,
        ST_PASS_B,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic active;
        op_t  op;
        logic found;
        logic freed;
    } probe_ctl_t;

endpackage

/* hdl/rct_cell.sv */
`timescale 1ns / 1ps

module rct_cell #(
    parameter int CELL_INDEX   = 0,
    parameter int SLOT_BITS    = 4,
    parameter int COUNT_BITS   = rct_pkg::COUNT_BITS_DEF,
    parameter int ADDRESS_BITS = rct_pkg::ADDRESS_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rct_pkg::probe_ctl_t     in_ctl,
    input  logic [ADDRESS_BITS-1:0] in_key,
    input  logic [SLOT_BITS-1:0]    in_slot,
    input  logic [COUNT_BITS-1:0]   in_count,
    output rct_pkg::probe_ctl_t     out_ctl,
    output logic [ADDRESS_BITS-1:0] out_key,
    output logic [SLOT_BITS-1:0]    out_slot,
    output logic [COUNT_BITS-1:0]   out_count
);
    import rct_pkg::*;

    localparam logic [SLOT_BITS-1:0]  MY_SLOT   = SLOT_BITS'(CELL_INDEX);
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                    valid_reg, valid_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    probe_ctl_t              ctl_reg, ctl_next;
    logic [ADDRESS_BITS-1:0] key_reg;
    logic [SLOT_BITS-1:0]    slot_reg, slot_next;
    logic [COUNT_BITS-1:0]   res_reg, res_next;
    logic                    match;
    logic                    hit;

    assign match = valid_reg && (addr_reg == in_key);
    assign hit   = in_ctl.active && !in_ctl.found &&
                   ((in_ctl.op == OP_REG) ? !valid_reg : match);

    always_comb begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        ctl_next   = in_ctl;
        slot_next  = in_slot;
        res_next   = in_count;
        if (hit) begin
            ctl_next.found = 1'b1;
            slot_next      = MY_SLOT;
            case (in_ctl.op)
                OP_REG: begin
                    valid_next = 1'b1;
                    addr_next  = in_key;
                    count_next = COUNT_ONE;
                    res_next   = COUNT_ONE;
                end
                OP_DEC: begin
                    if (count_reg <= COUNT_ONE) begin
                        valid_next     = 1'b0;
                        count_next     = '0;
                        res_next       = '0;
                        ctl_next.freed = 1'b1;
                    end else begin
                        count_next = count_reg - COUNT_ONE;
                        res_next   = count_reg - COUNT_ONE;
                    end
                end
                OP_INC: begin
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + COUNT_ONE;
                        res_next   = count_reg + COUNT_ONE;
                    end else begin
                        res_next = count_reg;
                    end
                end
                default: begin
                    ctl_next = in_ctl;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ctl_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            ctl_reg   <= ctl_next;
        end
        addr_reg  <= addr_next;
        count_reg <= count_next;
        key_reg   <= in_key;
        slot_reg  <= slot_next;
        res_reg   <= res_next;
    end

    assign out_ctl   = ctl_reg;
    assign out_key   = key_reg;
    assign out_slot  = slot_reg;
    assign out_count = res_reg;

endmodule

/* hdl/rct_ctrl.sv */
`timescale 1ns / 1ps

module rct_ctrl #(
    parameter int SLOT_BITS    = 4,
    parameter int COUNT_BITS   = rct_pkg::COUNT_BITS_DEF,
    parameter int ADDRESS_BITS = rct_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_cmd,
    input  logic [ADDRESS_BITS-1:0]               in_address,
    input  logic [ADDRESS_BITS-1:0]               in_new_address,
    output rct_pkg::probe_ctl_t                   launch_ctl,
    output logic [ADDRESS_BITS-1:0]               launch_key,
    input  rct_pkg::probe_ctl_t                   ret_ctl,
    input  logic [SLOT_BITS-1:0]                  ret_slot,
    input  logic [COUNT_BITS-1:0]                 ret_count,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [rct_pkg::OUT_STATUS_BITS-1:0]   out_status,
    output logic [rct_pkg::OUT_COUNT_BITS-1:0]    out_old_count,
    output logic                                  out_freed,
    output logic [rct_pkg::OUT_COUNT_BITS-1:0]    out_new_count,
    output logic [rct_pkg::OUT_SLOT_BITS-1:0]     out_slot
);
    import rct_pkg::*;

    state_t                      state_reg, state_next;
    logic                        cmd_reg;
    logic [ADDRESS_BITS-1:0]     naddr_reg;
    logic [OUT_STATUS_BITS-1:0]  status_reg;
    logic [OUT_COUNT_BITS-1:0]   oldc_reg;
    logic                        freed_reg;
    logic [OUT_COUNT_BITS-1:0]   newc_reg;
    logic [OUT_SLOT_BITS-1:0]    slot_reg;
    logic                        m_valid_reg;
    logic [OUT_STATUS_BITS-1:0]  m_status_reg;
    logic [OUT_COUNT_BITS-1:0]   m_oldc_reg;
    logic                        m_freed_reg;
    logic [OUT_COUNT_BITS-1:0]   m_newc_reg;
    logic [OUT_SLOT_BITS-1:0]    m_slot_reg;
    logic                        second_pass;
    logic                        load_out;
    logic                        accept;

    assign second_pass = (cmd_reg == CMD_ASSIGN) && ret_ctl.found && (naddr_reg != '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_PASS_A;
                end
            end
            ST_PASS_A: begin
                if (ret_ctl.active) begin
                    state_next = second_pass ? ST_PASS_B : ST_DONE;
                end
            end
            ST_PASS_B: begin
                if (ret_ctl.active) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready   = 1'b0;
        launch_ctl = '0;
        launch_key = naddr_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready          = 1'b1;
                launch_ctl.active = in_valid;
                launch_ctl.op     = (in_cmd == CMD_ASSIGN) ? OP_DEC : OP_REG;
                launch_key        = in_address;
            end
            ST_PASS_A: begin
                launch_ctl.active = ret_ctl.active && second_pass;
                launch_ctl.op     = OP_INC;
            end
            ST_PASS_B: begin
                launch_ctl = '0;
            end
            ST_DONE: begin
                load_out = !m_valid_reg || out_ready;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_ready && in_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= in_cmd;
            naddr_reg <= in_new_address;
        end
        if (state_reg == ST_PASS_A && ret_ctl.active) begin
            newc_reg <= '0;
            if (ret_ctl.found) begin
                status_reg <= STATUS_OK;
                oldc_reg   <= OUT_COUNT_BITS'(ret_count);
                slot_reg   <= OUT_SLOT_BITS'(ret_slot);
                freed_reg  <= ret_ctl.freed;
            end else begin
                status_reg <= (cmd_reg == CMD_ASSIGN) ? STATUS_OLD_MISSING : STATUS_FULL;
                oldc_reg   <= '0;
                slot_reg   <= '0;
                freed_reg  <= 1'b0;
            end
        end
        if (state_reg == ST_PASS_B && ret_ctl.active) begin
            if (ret_ctl.found) begin
                newc_reg <= OUT_COUNT_BITS'(ret_count);
            end else begin
                status_reg <= STATUS_NEW_MISSING;
                newc_reg   <= '0;
            end
        end
        if (load_out) begin
            m_status_reg <= status_reg;
            m_oldc_reg   <= oldc_reg;
            m_freed_reg  <= freed_reg;
            m_newc_reg   <= newc_reg;
            m_slot_reg   <= slot_reg;
        end
    end

    assign out_valid     = m_valid_reg;
    assign out_status    = m_status_reg;
    assign out_old_count = m_oldc_reg;
    assign out_freed     = m_freed_reg;
    assign out_new_count = m_newc_reg;
    assign out_slot      = m_slot_reg;

endmodule

/* hdl/reference_count_table_core.sv */
`timescale 1ns / 1ps

// Reference count table with one tracked address and count per cell.
// Commands arrive on the s_axis-style input channel: cmd 0 registers address in the
// lowest free cell with a count of one, cmd 1 decrements the count of address (freeing
// the cell at zero) and, if address was found, then increments the count of new_address
// unless it is zero. Each command produces exactly one result transfer on the m_ channel
// carrying status, both counts, the freed flag and the slot.
// A command travels as a probe along the row of cells, one cell per cycle. A register
// command makes one pass; an assign command whose old address was found and whose new
// address is non-null makes a second pass, launched as the first probe returns.
// One command is in progress at a time; s_tready is high only while the block is idle.
// The finished result sits in an output register, so the next command is accepted while
// it waits; if the receiver still holds m_tready low when a second result is ready, the
// block waits until the first has been taken.
// Reset clears every valid bit, so the table is empty and usable at once.
module reference_count_table_core #(
    parameter int TABLE_ENTRIES  = rct_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS     = rct_pkg::COUNT_BITS_DEF,
    parameter int ADDRESS_BITS   = rct_pkg::ADDRESS_BITS_DEF,
    localparam int IN_FIELD_BITS = 1 + 2 * ADDRESS_BITS,
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cmd, address, new_address
    input  logic [IN_DATA_BITS-1:0]           s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, old_count, freed, new_count, slot
    output logic [rct_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    import rct_pkg::*;

    localparam int SLOT_BITS = $clog2(TABLE_ENTRIES);

    probe_ctl_t              chain_ctl   [0:TABLE_ENTRIES];
    logic [ADDRESS_BITS-1:0] chain_key   [0:TABLE_ENTRIES];
    logic [SLOT_BITS-1:0]    chain_slot  [0:TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]   chain_count [0:TABLE_ENTRIES];

    logic [OUT_STATUS_BITS-1:0] status;
    logic [OUT_COUNT_BITS-1:0]  old_count;
    logic                       freed;
    logic [OUT_COUNT_BITS-1:0]  new_count;
    logic [OUT_SLOT_BITS-1:0]   slot;

    assign chain_slot[0]  = '0;
    assign chain_count[0] = '0;

    rct_ctrl #(
        .SLOT_BITS    (SLOT_BITS),
        .COUNT_BITS   (COUNT_BITS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_cmd         (s_tdata[0]),
        .in_address     (s_tdata[ADDRESS_BITS:1]),
        .in_new_address (s_tdata[2*ADDRESS_BITS:ADDRESS_BITS+1]),
        .launch_ctl     (chain_ctl[0]),
        .launch_key     (chain_key[0]),
        .ret_ctl        (chain_ctl[TABLE_ENTRIES]),
        .ret_slot       (chain_slot[TABLE_ENTRIES]),
        .ret_count      (chain_count[TABLE_ENTRIES]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (status),
        .out_old_count  (old_count),
        .out_freed      (freed),
        .out_new_count  (new_count),
        .out_slot       (slot)
    );

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        rct_cell #(
            .CELL_INDEX   (i),
            .SLOT_BITS    (SLOT_BITS),
            .COUNT_BITS   (COUNT_BITS),
            .ADDRESS_BITS (ADDRESS_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_ctl    (chain_ctl[i]),
            .in_key    (chain_key[i]),
            .in_slot   (chain_slot[i]),
            .in_count  (chain_count[i]),
            .out_ctl   (chain_ctl[i+1]),
            .out_key   (chain_key[i+1]),
            .out_slot  (chain_slot[i+1]),
            .out_count (chain_count[i+1])
        );
    end

    assign m_tdata = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}},
                      slot, new_count, freed, old_count, status};

endmodule

/* hdl/rct_checker.sv */
`timescale 1ns / 1ps

module rct_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rct_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    import rct_pkg::*;

    logic [OUT_STATUS_BITS-1:0] status;
    logic [OUT_COUNT_BITS-1:0]  old_count;
    logic                       freed;
    logic [OUT_COUNT_BITS-1:0]  new_count;
    logic [OUT_SLOT_BITS-1:0]   slot;

    assign {slot, new_count, freed, old_count, status} = m_tdata[OUT_FIELD_BITS-1:0];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result withdrawn before transfer");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("Result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Second command accepted while one is in progress");

    a_failed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status == STATUS_FULL || status == STATUS_OLD_MISSING) |->
        (old_count == '0 && !freed && new_count == '0 && slot == '0))
        else $error("Failed command reports non-zero fields");

    a_freed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && freed |-> old_count == '0)
        else $error("Freed entry reports a non-zero count");

endmodule

bind reference_count_table_core rct_checker u_rct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
